[design/lr_pkg.sv]
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared types and fixed widths for the Bresenham line walker.
// ----------------------------------------------------------------------------
package lr_pkg;

	localparam int COORD_W     = 8;
	localparam int ADDR_W      = 16;
	localparam int ERR_W       = 11;
	localparam int PIX_PER_GRP = 4;
	localparam int SLOT_W      = $clog2(PIX_PER_GRP);

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
	} line_cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] pixel_addr_0;
		logic [ADDR_W-1:0] pixel_addr_1;
		logic [ADDR_W-1:0] pixel_addr_2;
		logic [ADDR_W-1:0] pixel_addr_3;
		logic              write_0;
		logic              write_1;
		logic              write_2;
		logic              write_3;
		logic              last_group;
	} pix_group_t;

	// Status of the pixel under the walker
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              wr;
		logic              done;
	} step_stat_t;

endpackage

[design/line_rasterizer.sv]
// ----------------------------------------------------------------------------
// Line rasterizer
// Walks an all-octant Bresenham line and emits pixel writes in groups of four.
//
//   channel | dir | payload     | handshake
//   --------+-----+-------------+----------------------
//   cmd     | in  | line_cmd_t  | cmd_valid / cmd_stall
//   pix     | out | pix_group_t | pix_valid / pix_stall
//
// A line of n = max(|dx|,|dy|) + 1 pixels is loaded and then walked at one
// pixel per cycle through the single step unit unless the walker is held.
// A stalled output group holds the walker only when the next group is
// complete. cmd_stall stays high from the cycle after a command is taken
// until its last pixel is placed. Reset clears the control state only; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module line_rasterizer
	import lr_pkg::*;
#(
	parameter int SCREEN_SIZE = 240
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  line_cmd_t  cmd,
	output logic       pix_valid,
	input  logic       pix_stall,
	output pix_group_t pix
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	localparam logic [SLOT_W-1:0] SlotLast = SLOT_W'(PIX_PER_GRP - 1);

	state_t                  state_q;
	logic [COORD_W-1:0]      cur_x_q;
	logic [COORD_W-1:0]      cur_y_q;
	logic signed [ERR_W-1:0] err_q;
	logic [COORD_W-1:0]      abs_dx_q;
	logic signed [ERR_W-1:0] neg_dy_q;
	logic [1:0]              dirs_q;
	logic [COORD_W-1:0]      end_x_q;
	logic [COORD_W-1:0]      end_y_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [ADDR_W-1:0]       grp_addr_q [PIX_PER_GRP];
	logic                    grp_wr_q   [PIX_PER_GRP];
	logic                    pix_valid_q;
	pix_group_t              pix_q;

	logic [COORD_W-1:0]      next_x;
	logic [COORD_W-1:0]      next_y;
	logic signed [ERR_W-1:0] next_err;
	step_stat_t              stat;

	logic                    cmd_take;
	logic                    walking;
	logic                    push_need;
	logic                    out_free;
	logic                    advance;
	logic                    push;
	logic [COORD_W-1:0]      adx;
	logic [COORD_W-1:0]      ady;
	logic [ERR_W-1:0]        neg_ady;
	logic [ADDR_W-1:0]       m_addr [PIX_PER_GRP];
	logic                    m_wr   [PIX_PER_GRP];
	pix_group_t              grp_next;

	lr_step #(
		.SCREEN_SIZE(SCREEN_SIZE)
	) u_step (
		.cur_x     (cur_x_q),
		.cur_y     (cur_y_q),
		.err       (err_q),
		.abs_dx    (abs_dx_q),
		.neg_abs_dy(neg_dy_q),
		.dirs      (dirs_q),
		.end_x     (end_x_q),
		.end_y     (end_y_q),
		.next_x    (next_x),
		.next_y    (next_y),
		.next_err  (next_err),
		.stat      (stat)
	);

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign walking   = (state_q == ST_WALK);
	assign push_need = stat.done || (slot_q == SlotLast);
	assign out_free  = !pix_valid_q || !pix_stall;
	assign advance   = walking && (!push_need || out_free);
	assign push      = advance && push_need;

	assign adx     = (cmd.end_x > cmd.start_x) ? cmd.end_x - cmd.start_x
	                                            : cmd.start_x - cmd.end_x;
	assign ady     = (cmd.end_y > cmd.start_y) ? cmd.end_y - cmd.start_y
	                                            : cmd.start_y - cmd.end_y;
	assign neg_ady = ERR_W'(0) - {(ERR_W-COORD_W)'(0), ady};

	// Slots behind the current one come from the group, later ones stay empty
	always_comb begin
		for (int i = 0; i < PIX_PER_GRP; i++) begin
			if (SLOT_W'(i) < slot_q) begin
				m_addr[i] = grp_addr_q[i];
				m_wr[i]   = grp_wr_q[i];
			end else if (SLOT_W'(i) == slot_q) begin
				m_addr[i] = stat.addr;
				m_wr[i]   = stat.wr;
			end else begin
				m_addr[i] = '0;
				m_wr[i]   = 1'b0;
			end
		end
		grp_next.pixel_addr_0 = m_addr[0];
		grp_next.pixel_addr_1 = m_addr[1];
		grp_next.pixel_addr_2 = m_addr[2];
		grp_next.pixel_addr_3 = m_addr[3];
		grp_next.write_0      = m_wr[0];
		grp_next.write_1      = m_wr[1];
		grp_next.write_2      = m_wr[2];
		grp_next.write_3      = m_wr[3];
		grp_next.last_group   = stat.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			pix_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						state_q <= ST_WALK;
						slot_q  <= '0;
					end
				end
				ST_WALK: begin
					if (advance) begin
						slot_q <= push_need ? '0 : slot_q + 1'b1;
						if (stat.done) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (push) begin
				pix_valid_q <= 1'b1;
			end else if (!pix_stall) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cur_x_q  <= cmd.start_x;
			cur_y_q  <= cmd.start_y;
			abs_dx_q <= adx;
			neg_dy_q <= $signed(neg_ady);
			err_q    <= $signed({(ERR_W-COORD_W)'(0), adx} + neg_ady);
			dirs_q   <= {!(cmd.start_y < cmd.end_y), !(cmd.start_x < cmd.end_x)};
			end_x_q  <= cmd.end_x;
			end_y_q  <= cmd.end_y;
		end else if (advance) begin
			cur_x_q <= next_x;
			cur_y_q <= next_y;
			err_q   <= next_err;
		end
		if (advance && !push_need) begin
			grp_addr_q[slot_q] <= stat.addr;
			grp_wr_q[slot_q]   <= stat.wr;
		end
		if (push) begin
			pix_q <= grp_next;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

endmodule

[design/lr_step.sv]
// ----------------------------------------------------------------------------
// Line rasterizer step unit
// Addresses and clips the current pixel, and computes one Bresenham step.
// ----------------------------------------------------------------------------
module lr_step
	import lr_pkg::*;
#(
	parameter int SCREEN_SIZE = 240
) (
	input  logic [COORD_W-1:0]     cur_x,
	input  logic [COORD_W-1:0]     cur_y,
	input  logic signed [ERR_W-1:0] err,
	input  logic [COORD_W-1:0]     abs_dx,
	input  logic signed [ERR_W-1:0] neg_abs_dy,
	input  logic [1:0]             dirs,
	input  logic [COORD_W-1:0]     end_x,
	input  logic [COORD_W-1:0]     end_y,
	output logic [COORD_W-1:0]     next_x,
	output logic [COORD_W-1:0]     next_y,
	output logic signed [ERR_W-1:0] next_err,
	output step_stat_t             stat
);

	localparam logic [ADDR_W-1:0]  ScreenW = ADDR_W'(SCREEN_SIZE);
	localparam logic [COORD_W:0]   ScreenC = (COORD_W+1)'(SCREEN_SIZE);

	logic signed [ERR_W:0]   twice;
	logic signed [ERR_W:0]   dy_ext;
	logic signed [ERR_W:0]   dx_ext;
	logic                    step_x;
	logic                    step_y;
	logic [ERR_W-1:0]        add_x;
	logic [ERR_W-1:0]        add_y;
	logic [ADDR_W-1:0]       lin_addr;
	logic                    on_screen;

	assign twice  = {err, 1'b0};
	assign dy_ext = {neg_abs_dy[ERR_W-1], neg_abs_dy};
	assign dx_ext = $signed({(ERR_W+1-COORD_W)'(0), abs_dx});
	assign step_x = (twice >= dy_ext);
	assign step_y = (twice <= dx_ext);

	assign add_x    = step_x ? neg_abs_dy : '0;
	assign add_y    = step_y ? {(ERR_W-COORD_W)'(0), abs_dx} : '0;
	assign next_err = $signed(err + add_x + add_y);

	assign next_x = step_x ? (dirs[0] ? cur_x - 1'b1 : cur_x + 1'b1) : cur_x;
	assign next_y = step_y ? (dirs[1] ? cur_y - 1'b1 : cur_y + 1'b1) : cur_y;

	assign lin_addr  = ADDR_W'(cur_y) * ScreenW + ADDR_W'(cur_x);
	assign on_screen = ({1'b0, cur_x} < ScreenC) && ({1'b0, cur_y} < ScreenC);

	assign stat.addr = on_screen ? lin_addr : '0;
	assign stat.wr   = on_screen;
	assign stat.done = (cur_x == end_x) && (cur_y == end_y);

endmodule

[design/lr_checker.sv]
// ----------------------------------------------------------------------------
// Line rasterizer checker
// Port-level assertions on the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module lr_checker
	import lr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_stall,
	input line_cmd_t  cmd,
	input logic       pix_valid,
	input logic       pix_stall,
	input pix_group_t pix
);

	// A stalled group holds
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pix))
		else $error("pix group changed while stalled");

	// A stalled command holds
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
		else $error("cmd item changed while stalled");

	// A taken command keeps the input closed while it is walked
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("cmd input open right after a command was taken");

	// Once idle, only the final group of a line can still wait
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !cmd_stall |-> pix.last_group)
		else $error("non-final group pending while idle");

	// A clipped or unused last slot (slot 3) carries a zero address
	a_clip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix.write_3 |-> pix.pixel_addr_3 == '0)
		else $error("unwritten slot with nonzero address");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.cmd      (cmd),
	.pix_valid(pix_valid),
	.pix_stall(pix_stall),
	.pix      (pix)
);
